/* src/dwp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwp_pkg - shared types and constants of the dual wheel PID controller
// Field widths, register indexes, gain bundle and pipeline control word.
// ----------------------------------------------------------------------------
package dwp_pkg;

    localparam int GAIN_W     = 40;
    localparam int CEIL_W     = 10;
    localparam int SPEED_W    = 10;
    localparam int COUNT_W    = 17;
    localparam int DUTY_W     = 10;
    localparam int ERR_W      = 18;
    localparam int DIFF_W     = 19;
    localparam int SUM_W      = 40;
    localparam int ACC_W      = 42;
    localparam int FRAC_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_STAGES = 5;

    localparam logic [5:0] SPEED_SCALE = 6'd50;

    // integral term magnitude limit, 2^60
    localparam logic [60:0] INT_TERM_LIM = {1'b1, 60'd0};

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST = 40'd1717986918;
    localparam logic [GAIN_W-1:0] INT_GAIN_RST  = 40'd3865;
    localparam logic [GAIN_W-1:0] DIFF_GAIN_RST = 40'd644245094;
    localparam logic [CEIL_W-1:0] CEIL_RST      = 10'd400;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_PROP  = 3'd0,
        REG_LEFT_INT   = 3'd1,
        REG_LEFT_DIFF  = 3'd2,
        REG_RIGHT_PROP = 3'd3,
        REG_RIGHT_INT  = 3'd4,
        REG_RIGHT_DIFF = 3'd5,
        REG_DUTY_CEIL  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] prop;
        logic [GAIN_W-1:0] integ;
        logic [GAIN_W-1:0] diff;
    } wheel_gain_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

endpackage
`default_nettype wire

/* src/dual_wheel_incremental_pid.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_wheel_incremental_pid - two-wheel incremental PID speed controller
// One word per control period; returns the clamped integer duty of each wheel.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | target_speed, left_count, right_count
//   out     | out_valid / out_ready| left_duty, right_duty
//   cfg     | cfg_we               | cfg_index, cfg_data
//
// Five-stage pipeline: error and integral, split gain products, terms, sum,
// clamped duty update. One word per cycle while the output is not stalled;
// the result is presented once the word reaches the last stage.
// Wheel state advances as a word enters stage one and as it reaches the output.
// Reset clears integrals, previous errors and duties and loads default gains.
// A stalled output holds its stage; earlier stages keep filling until full.
// ----------------------------------------------------------------------------
module dual_wheel_incremental_pid (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [dwp_pkg::SPEED_W-1:0]            target_speed,
    input  wire logic signed [dwp_pkg::COUNT_W-1:0]     left_count,
    input  wire logic signed [dwp_pkg::COUNT_W-1:0]     right_count,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [dwp_pkg::DUTY_W-1:0]                  left_duty,
    output logic [dwp_pkg::DUTY_W-1:0]                  right_duty,
    input  wire logic                                   cfg_we,
    input  wire logic [dwp_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [dwp_pkg::GAIN_W-1:0]             cfg_data
);

    dwp_pkg::wheel_gain_t           left_gain;
    dwp_pkg::wheel_gain_t           right_gain;
    logic [dwp_pkg::CEIL_W-1:0]     duty_ceiling;
    dwp_pkg::pipe_ctrl_t            ctrl;

    dwp_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .left_gain    (left_gain),
        .right_gain   (right_gain),
        .duty_ceiling (duty_ceiling)
    );

    dwp_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    dwp_wheel u_left (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .gain         (left_gain),
        .duty_ceiling (duty_ceiling),
        .target_speed (target_speed),
        .count        (left_count),
        .duty         (left_duty)
    );

    dwp_wheel u_right (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .gain         (right_gain),
        .duty_ceiling (duty_ceiling),
        .target_speed (target_speed),
        .count        (right_count),
        .duty         (right_duty)
    );

endmodule
`default_nettype wire

/* src/dwp_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwp_cfg - configuration register file
// Holds the six gains and the duty ceiling; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module dwp_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [dwp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dwp_pkg::GAIN_W-1:0]         cfg_data,
    output dwp_pkg::wheel_gain_t                    left_gain,
    output dwp_pkg::wheel_gain_t                    right_gain,
    output logic [dwp_pkg::CEIL_W-1:0]              duty_ceiling
);

    dwp_pkg::wheel_gain_t              left_reg;
    dwp_pkg::wheel_gain_t              right_reg;
    logic [dwp_pkg::CEIL_W-1:0]        ceil_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg.prop   <= dwp_pkg::PROP_GAIN_RST;
            left_reg.integ  <= dwp_pkg::INT_GAIN_RST;
            left_reg.diff   <= dwp_pkg::DIFF_GAIN_RST;
            right_reg.prop  <= dwp_pkg::PROP_GAIN_RST;
            right_reg.integ <= dwp_pkg::INT_GAIN_RST;
            right_reg.diff  <= dwp_pkg::DIFF_GAIN_RST;
            ceil_reg        <= dwp_pkg::CEIL_RST;
        end
        else if (cfg_we)
        begin
            unique case (dwp_pkg::reg_idx_t'(cfg_index))
                dwp_pkg::REG_LEFT_PROP:  left_reg.prop   <= cfg_data;
                dwp_pkg::REG_LEFT_INT:   left_reg.integ  <= cfg_data;
                dwp_pkg::REG_LEFT_DIFF:  left_reg.diff   <= cfg_data;
                dwp_pkg::REG_RIGHT_PROP: right_reg.prop  <= cfg_data;
                dwp_pkg::REG_RIGHT_INT:  right_reg.integ <= cfg_data;
                dwp_pkg::REG_RIGHT_DIFF: right_reg.diff  <= cfg_data;
                dwp_pkg::REG_DUTY_CEIL:  ceil_reg        <= cfg_data[dwp_pkg::CEIL_W-1:0];
                default: ;
            endcase
        end
    end

    assign left_gain    = left_reg;
    assign right_gain   = right_reg;
    assign duty_ceiling = ceil_reg;

endmodule
`default_nettype wire

/* src/dwp_pipe_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwp_pipe_ctrl - pipeline occupancy and flow control
// Tracks a valid bit per stage and lets each stage advance when the next frees.
// ----------------------------------------------------------------------------
module dwp_pipe_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output dwp_pkg::pipe_ctrl_t  ctrl
);

    localparam int N = dwp_pkg::NUM_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N-1:0] stage_ready;
    logic [N-1:0] load;

    always_comb
    begin
        stage_ready[N-1] = !valid_reg[N-1] || out_ready;
        for (int k = N - 2; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
        load[0] = in_valid && stage_ready[0];
        for (int k = 1; k < N; k++)
        begin
            load[k] = valid_reg[k-1] && stage_ready[k];
        end
        valid_next = load | (valid_reg & ~stage_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[N-1];
    assign ctrl.load = load;

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !out_ready |-> !in_ready)
        else $error("full stalled pipeline still takes a word");

    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[N-1] |-> in_ready)
        else $error("input refused with empty output stage");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted word lost at first stage");

    a_last_load: assert property (@(posedge clk) disable iff (!rst_n)
        load[N-1] |=> out_valid)
        else $error("result loaded but not presented");

endmodule
`default_nettype wire

/* src/dwp_wheel.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwp_wheel - incremental PID datapath for one wheel
// Error and integral, split products, terms, sum, then clamped duty update.
// ----------------------------------------------------------------------------
module dwp_wheel (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire dwp_pkg::pipe_ctrl_t                    ctrl,
    input  wire dwp_pkg::wheel_gain_t                   gain,
    input  wire logic [dwp_pkg::CEIL_W-1:0]             duty_ceiling,
    input  wire logic [dwp_pkg::SPEED_W-1:0]            target_speed,
    input  wire logic signed [dwp_pkg::COUNT_W-1:0]     count,
    output logic [dwp_pkg::DUTY_W-1:0]                  duty
);

    localparam int HW = dwp_pkg::GAIN_W / 2;

    // wheel state
    logic signed [dwp_pkg::SUM_W-1:0]   err_sum_reg;
    logic signed [dwp_pkg::ERR_W-1:0]   prev_err_reg;
    logic [dwp_pkg::ACC_W-1:0]          acc_reg;

    // stage 1
    logic [15:0]                        tgt_scaled;
    logic signed [dwp_pkg::ERR_W-1:0]   err_next;
    logic signed [dwp_pkg::SUM_W:0]     sum_wide;
    logic signed [dwp_pkg::SUM_W-1:0]   sum_next;
    logic signed [dwp_pkg::DIFF_W-1:0]  diff_next;
    logic signed [dwp_pkg::ERR_W-1:0]   e_s1_reg;
    logic signed [dwp_pkg::SUM_W-1:0]   s_s1_reg;
    logic signed [dwp_pkg::DIFF_W-1:0]  d_s1_reg;

    // stage 2
    logic [dwp_pkg::SUM_W-1:0]          sum_mag;
    logic signed [38:0]                 ph_reg;
    logic signed [38:0]                 pl_reg;
    logic signed [39:0]                 dh_reg;
    logic signed [39:0]                 dl_reg;
    logic [39:0]                        ihh_reg;
    logic [39:0]                        ihl_reg;
    logic [39:0]                        ilh_reg;
    logic [39:0]                        ill_reg;
    logic                               neg_s2_reg;

    // stage 3
    logic [40:0]                        int_mid;
    logic [79:0]                        int_exact;
    logic [60:0]                        int_mag;
    logic signed [57:0]                 prop_term_reg;
    logic signed [58:0]                 diff_term_reg;
    logic signed [61:0]                 int_term_reg;

    // stage 4
    logic signed [62:0]                 delta_reg;

    // stage 5
    logic signed [63:0]                 total;
    logic signed [63:0]                 ceil_q;
    logic [dwp_pkg::ACC_W-1:0]          acc_next;

    always_comb
    begin
        tgt_scaled = 16'(16'(target_speed) * dwp_pkg::SPEED_SCALE);
        err_next   = $signed({2'b00, tgt_scaled}) - dwp_pkg::ERR_W'(count);
        sum_wide   = (dwp_pkg::SUM_W+1)'(err_sum_reg) + (dwp_pkg::SUM_W+1)'(err_next);
        if (sum_wide[dwp_pkg::SUM_W] != sum_wide[dwp_pkg::SUM_W-1])
        begin
            sum_next = sum_wide[dwp_pkg::SUM_W] ? {1'b1, {(dwp_pkg::SUM_W-1){1'b0}}}
                                                : {1'b0, {(dwp_pkg::SUM_W-1){1'b1}}};
        end
        else
        begin
            sum_next = sum_wide[dwp_pkg::SUM_W-1:0];
        end
        diff_next = dwp_pkg::DIFF_W'(err_next) - dwp_pkg::DIFF_W'(prev_err_reg);
    end

    always_comb
    begin
        sum_mag = s_s1_reg[dwp_pkg::SUM_W-1] ? dwp_pkg::SUM_W'(-s_s1_reg)
                                             : dwp_pkg::SUM_W'(s_s1_reg);
    end

    always_comb
    begin
        int_mid   = 41'(ihl_reg) + 41'(ilh_reg);
        int_exact = {ihh_reg, 40'd0} + {19'd0, int_mid, 20'd0} + {40'd0, ill_reg};
        int_mag   = (int_exact > 80'(dwp_pkg::INT_TERM_LIM)) ? dwp_pkg::INT_TERM_LIM
                                                            : int_exact[60:0];
    end

    always_comb
    begin
        total  = $signed({22'd0, acc_reg}) + 64'(delta_reg);
        ceil_q = $signed({22'd0, duty_ceiling, 32'd0});
        if (total >= ceil_q)
        begin
            acc_next = ceil_q[dwp_pkg::ACC_W-1:0];
        end
        else if (total <= 64'sd0)
        begin
            acc_next = '0;
        end
        else
        begin
            acc_next = total[dwp_pkg::ACC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_sum_reg  <= '0;
            prev_err_reg <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            if (ctrl.load[0])
            begin
                err_sum_reg  <= sum_next;
                prev_err_reg <= err_next;
            end
            if (ctrl.load[4])
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            e_s1_reg <= err_next;
            s_s1_reg <= sum_next;
            d_s1_reg <= diff_next;
        end
        if (ctrl.load[1])
        begin
            ph_reg     <= 39'($signed({1'b0, gain.prop[2*HW-1:HW]})) * 39'(e_s1_reg);
            pl_reg     <= 39'($signed({1'b0, gain.prop[HW-1:0]})) * 39'(e_s1_reg);
            dh_reg     <= 40'($signed({1'b0, gain.diff[2*HW-1:HW]})) * 40'(d_s1_reg);
            dl_reg     <= 40'($signed({1'b0, gain.diff[HW-1:0]})) * 40'(d_s1_reg);
            ihh_reg    <= 40'(sum_mag[2*HW-1:HW]) * 40'(gain.integ[2*HW-1:HW]);
            ihl_reg    <= 40'(sum_mag[2*HW-1:HW]) * 40'(gain.integ[HW-1:0]);
            ilh_reg    <= 40'(sum_mag[HW-1:0]) * 40'(gain.integ[2*HW-1:HW]);
            ill_reg    <= 40'(sum_mag[HW-1:0]) * 40'(gain.integ[HW-1:0]);
            neg_s2_reg <= s_s1_reg[dwp_pkg::SUM_W-1];
        end
        if (ctrl.load[2])
        begin
            prop_term_reg <= (58'(ph_reg) <<< HW) + 58'(pl_reg);
            diff_term_reg <= (59'(dh_reg) <<< HW) + 59'(dl_reg);
            int_term_reg  <= neg_s2_reg ? -$signed({1'b0, int_mag})
                                        : $signed({1'b0, int_mag});
        end
        if (ctrl.load[3])
        begin
            delta_reg <= 63'(prop_term_reg) + 63'(int_term_reg) + 63'(diff_term_reg);
        end
    end

    assign duty = acc_reg[dwp_pkg::FRAC_W +: dwp_pkg::DUTY_W];

    a_int_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        $past(ctrl.load[2]) |->
            (int_term_reg <= $signed({1'b0, dwp_pkg::INT_TERM_LIM})) &&
            (int_term_reg >= -$signed({1'b0, dwp_pkg::INT_TERM_LIM})))
        else $error("integral term beyond saturation limit");

    a_zero_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.load[0] |=> $stable(err_sum_reg) && $stable(prev_err_reg))
        else $error("wheel state moved without a word");

    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.load[4] |=> $stable(acc_reg))
        else $error("duty moved without a word");

endmodule
`default_nettype wire
